@@ rtl/pmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int BYTE_W         = 8;
    localparam int REG_W          = 13;
    localparam int OUT_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int DELTA_W        = 10;

    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_XSIGN_BIT  = 4;
    localparam int HDR_YSIGN_BIT  = 5;
    localparam int EDGE_GAP       = 5;

    localparam int POS_X_RESET    = 512;
    localparam int POS_Y_RESET    = 384;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd768;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef struct packed {
        logic                      fire;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } move_t;

endpackage

@@ rtl/pmt_if.sv @@
// ----------------------------------------------------------------------------
// pmt_if
// Handshake channels: received bytes, cursor results and register writes.
// ----------------------------------------------------------------------------
interface pmt_in_if;
    logic                        valid;
    logic                        ready;
    logic [pmt_pkg::BYTE_W-1:0]  rx_byte;
    logic                        from_aux;

    modport source (output valid, output rx_byte, output from_aux, input ready);
    modport sink   (input valid, input rx_byte, input from_aux, output ready);
endinterface

interface pmt_out_if;
    logic                       valid;
    logic                       ready;
    logic [pmt_pkg::OUT_W-1:0]  cursor_x;
    logic [pmt_pkg::OUT_W-1:0]  cursor_y;
    logic                       packet_done;

    modport source (output valid, output cursor_x, output cursor_y,
                    output packet_done, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input packet_done, output ready);
endinterface

interface pmt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pmt_pkg::CFG_IDX_W-1:0]  index;
    logic [pmt_pkg::REG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pmt_framer.sv @@
// ----------------------------------------------------------------------------
// pmt_framer
// Assembles three-byte mouse packets and emits signed X/Y moves.
// ----------------------------------------------------------------------------
module pmt_framer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [pmt_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        from_aux,
    output pmt_pkg::move_t              move
);

    localparam logic [1:0] PH_HEAD  = 2'd0;
    localparam logic [1:0] PH_XBYTE = 2'd1;
    localparam logic [1:0] PH_YBYTE = 2'd2;

    logic [1:0]                 phase_reg, phase_next;
    logic [pmt_pkg::BYTE_W-1:0] header_reg, header_next;
    logic [pmt_pkg::BYTE_W-1:0] xbyte_reg, xbyte_next;
    logic [pmt_pkg::BYTE_W:0]   dx9;
    logic [pmt_pkg::BYTE_W:0]   dy9;
    logic                       fire;

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xbyte_next  = xbyte_reg;
        fire        = 1'b0;
        if (en && from_aux)
        begin
            case (phase_reg)
                PH_XBYTE:
                begin
                    xbyte_next = rx_byte;
                    phase_next = PH_YBYTE;
                end
                PH_YBYTE:
                begin
                    fire       = 1'b1;
                    phase_next = PH_HEAD;
                end
                default:
                begin
                    if (rx_byte[pmt_pkg::HDR_SYNC_BIT])
                    begin
                        header_next = rx_byte;
                        phase_next  = PH_XBYTE;
                    end
                    else
                    begin
                        phase_next = PH_HEAD;
                    end
                end
            endcase
        end
    end

    assign dx9       = {header_reg[pmt_pkg::HDR_XSIGN_BIT], xbyte_reg};
    assign dy9       = {header_reg[pmt_pkg::HDR_YSIGN_BIT], rx_byte};
    assign move.fire = fire;
    assign move.dx   = $signed({dx9[pmt_pkg::BYTE_W], dx9});
    // screen Y grows downward
    assign move.dy   = -$signed({dy9[pmt_pkg::BYTE_W], dy9});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            header_reg <= '0;
            xbyte_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xbyte_reg  <= xbyte_next;
        end
    end

endmodule

@@ rtl/pmt_axis.sv @@
// ----------------------------------------------------------------------------
// pmt_axis
// One cursor axis: position register with add and clamp to size minus five.
// ----------------------------------------------------------------------------
module pmt_axis
#(
    parameter int COORD_BITS = pmt_pkg::COORD_BITS_DEF,
    parameter int RESET_POS  = pmt_pkg::POS_X_RESET
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic signed [pmt_pkg::DELTA_W-1:0] delta,
    input  logic [pmt_pkg::REG_W-1:0]          size,
    output logic [COORD_BITS-1:0]              pos_next
);

    localparam int CALC_W = ((COORD_BITS > pmt_pkg::REG_W) ? COORD_BITS : pmt_pkg::REG_W) + 2;
    localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'((1 << COORD_BITS) - 1);
    localparam logic signed [CALC_W-1:0] GAP     = CALC_W'(pmt_pkg::EDGE_GAP);

    logic [COORD_BITS-1:0]       pos_reg;
    logic signed [CALC_W-1:0]    size_s;
    logic signed [CALC_W-1:0]    lim_raw;
    logic signed [CALC_W-1:0]    lim;
    logic signed [CALC_W-1:0]    sum;
    logic signed [CALC_W-1:0]    clamped;

    assign size_s  = $signed({{(CALC_W-pmt_pkg::REG_W){1'b0}}, size});
    assign lim_raw = size_s - GAP;
    assign sum     = $signed({{(CALC_W-COORD_BITS){1'b0}}, pos_reg})
                   + $signed({{(CALC_W-pmt_pkg::DELTA_W){delta[pmt_pkg::DELTA_W-1]}}, delta});

    always_comb
    begin
        if (size_s < GAP)
            lim = '0;
        else if (lim_raw > POS_MAX)
            lim = POS_MAX;
        else
            lim = lim_raw;

        if (sum < 0)
            clamped = '0;
        else if (sum > lim)
            clamped = lim;
        else
            clamped = sum;
    end

    assign pos_next = en ? clamped[COORD_BITS-1:0] : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= COORD_BITS'(RESET_POS);
        else
            pos_reg <= pos_next;
    end

endmodule

@@ rtl/ps2_mouse_packet_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Tracks a clamped cursor position from PS/2 mouse packet bytes.
// ----------------------------------------------------------------------------
// Takes one controller byte per item with its auxiliary-port flag and
// returns one result per item: the cursor position after that byte and a
// flag set when the byte completed a three-byte packet. Bytes not from the
// auxiliary port leave the state alone. Items are accepted every cycle
// while results are taken; each passes an input register, the packet
// framer plus add-and-clamp, and a result register, and a held-off
// result stalls the input once both registers are full. Position resets
// to 512,384; screen size registers reset to 1024x768 and are to be
// written only while the block is idle; the block itself does not
// enforce this.
module ps2_mouse_packet_tracker
#(
    parameter int COORD_BITS = pmt_pkg::COORD_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pmt_in_if.sink     in_item,
    pmt_out_if.source  out_item,
    pmt_cfg_if.sink    cfg
);

    localparam int EXT_W = (COORD_BITS > pmt_pkg::OUT_W) ? COORD_BITS : pmt_pkg::OUT_W;

    logic [pmt_pkg::REG_W-1:0]  width_reg;
    logic [pmt_pkg::REG_W-1:0]  height_reg;

    logic                       s1_valid_reg;
    logic [pmt_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                       s1_aux_reg;

    logic                       out_valid_reg;
    logic [pmt_pkg::OUT_W-1:0]  out_x_reg;
    logic [pmt_pkg::OUT_W-1:0]  out_y_reg;
    logic                       out_done_reg;

    logic                       proc;
    pmt_pkg::move_t             move;
    logic [COORD_BITS-1:0]      x_next;
    logic [COORD_BITS-1:0]      y_next;
    logic [EXT_W-1:0]           x_ext;
    logic [EXT_W-1:0]           y_ext;

    assign proc          = s1_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !s1_valid_reg || proc;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pmt_pkg::WIDTH_RESET;
            height_reg <= pmt_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pmt_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg.data;
                pmt_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_item.valid && in_item.ready)
            s1_valid_reg <= 1'b1;
        else if (proc)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            s1_byte_reg <= in_item.rx_byte;
            s1_aux_reg  <= in_item.from_aux;
        end
    end

    pmt_framer u_framer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (proc),
        .rx_byte  (s1_byte_reg),
        .from_aux (s1_aux_reg),
        .move     (move)
    );

    pmt_axis #(
        .COORD_BITS (COORD_BITS),
        .RESET_POS  (pmt_pkg::POS_X_RESET)
    ) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (move.fire),
        .delta    (move.dx),
        .size     (width_reg),
        .pos_next (x_next)
    );

    pmt_axis #(
        .COORD_BITS (COORD_BITS),
        .RESET_POS  (pmt_pkg::POS_Y_RESET)
    ) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (move.fire),
        .delta    (move.dy),
        .size     (height_reg),
        .pos_next (y_next)
    );

    assign x_ext = EXT_W'(x_next);
    assign y_ext = EXT_W'(y_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc)
            out_valid_reg <= 1'b1;
        else if (out_item.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_x_reg    <= x_ext[pmt_pkg::OUT_W-1:0];
            out_y_reg    <= y_ext[pmt_pkg::OUT_W-1:0];
            out_done_reg <= move.fire;
        end
    end

    assign out_item.valid       = out_valid_reg;
    assign out_item.cursor_x    = out_x_reg;
    assign out_item.cursor_y    = out_y_reg;
    assign out_item.packet_done = out_done_reg;

endmodule
